// ===== hw/rtl/ffas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffas_pkg
// Shared types, codes and defaults of the first-fit aligned suballocator.
// ----------------------------------------------------------------------------
package ffas_pkg;

	localparam int DEF_MEMORY_TYPES = 8;
	localparam int DEF_HEAPS        = 2;
	localparam int DEF_SEGMENTS     = 16;

	localparam int W         = 36;
	localparam int ALIGN_MAX = 35;

	localparam logic [2:0] CFG_HEAP0   = 3'd0;
	localparam logic [2:0] CFG_HEAP1   = 3'd1;
	localparam logic [2:0] CFG_HEAP2   = 3'd2;
	localparam logic [2:0] CFG_HEAP3   = 3'd3;
	localparam logic [2:0] CFG_THRESH  = 3'd4;
	localparam logic [2:0] CFG_ROUTING = 3'd5;
	localparam logic [2:0] CFG_TYPES   = 3'd6;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_TOO_LARGE  = 3'd1,
		ST_NO_SPACE   = 3'd2,
		ST_TABLE_FULL = 3'd3,
		ST_BAD        = 3'd4
	} status_t;

	typedef struct packed {
		logic [W-1:0] off;
		logic [W-1:0] len;
	} seg_t;

	typedef enum logic [2:0] {J_HOLD, J_ZERO, J_INC, J_DEC, J_CNT} j_op_t;
	typedef enum logic [1:0] {P_HOLD, P_J, P_J1} pos_op_t;
	typedef enum logic [1:0] {H_HOLD, H_START, H_FREE, H_INC} h_op_t;
	typedef enum logic [1:0] {RD_NONE, RD_J, RD_JP1, RD_JM1} rd_sel_t;
	typedef enum logic [3:0] {
		WR_NONE, WR_OPEN, WR_SHIFT, WR_INS, WR_TAIL, WR_HEAD, WR_MBOTH, WR_MPREV, WR_MNEXT
	} wr_sel_t;
	typedef enum logic [1:0] {C_HOLD, C_INC, C_DEC} cnt_op_t;

	typedef struct packed {
		logic    load_req;
		logic    open_pool;
		logic    cur_load;
		logic    scan_take;
		logic    ins_load;
		logic    res_load;
		status_t res_code;
		j_op_t   j_op;
		pos_op_t pos_op;
		h_op_t   h_op;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		cnt_op_t cnt_op;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic bad_alloc;
		logic bad_free;
		logic too_large;
		logic zero_size;
		logic opened;
		logic j_eq_cnt;
		logic j1_eq_cnt;
		logic j_eq_pos;
		logic heap_last;
		logic fit;
		logic pad_zero;
		logic room_eq_req;
		logic table_full;
		logic le;
		logic f_bad;
		logic mprev;
		logic mnext;
	} sts_t;

endpackage

// ===== hw/rtl/first_fit_aligned_suballocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_aligned_suballocator_core
// First-fit suballocator with alignment and coalescing free segment tables,
// one pool for each memory type and heap.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  request  in_valid / in_stall   op, memory_type, req_size, align_log2,
//                                 free_heap, free_offset
//  result   out_valid / out_stall status, heap_index, block_offset, block_size
//  config   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction at a time; a new request is taken only in the idle state.
// An allocate visits each segment of a heap in turn, then the next heap when
// none fits; a free scans the entries of its pool in order. Entries behind
// an inserted or removed entry are shifted one by one.
// The walk reads the segment table RAM through its one read port.
// Reset clears pool counts and open flags at once; no clearing pass.
// A result is held while out_stall is high and no request is taken then.
module first_fit_aligned_suballocator_core #(
	parameter int MEMORY_TYPES = ffas_pkg::DEF_MEMORY_TYPES,
	parameter int HEAPS        = ffas_pkg::DEF_HEAPS,
	parameter int SEGMENTS     = ffas_pkg::DEF_SEGMENTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [2:0]  memory_type,
	input  logic [35:0] req_size,
	input  logic [5:0]  align_log2,
	input  logic [1:0]  free_heap,
	input  logic [35:0] free_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [1:0]  heap_index,
	output logic [35:0] block_offset,
	output logic [35:0] block_size,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [35:0] cfg_data
);
	import ffas_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ffas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffas_dp #(
		.MEMORY_TYPES(MEMORY_TYPES),
		.HEAPS       (HEAPS),
		.SEGMENTS    (SEGMENTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.memory_type (memory_type),
		.req_size    (req_size),
		.align_log2  (align_log2),
		.free_heap   (free_heap),
		.free_offset (free_offset),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.status      (status),
		.heap_index  (heap_index),
		.block_offset(block_offset),
		.block_size  (block_size)
	);
endmodule

// ===== hw/rtl/ffas_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffas_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffas_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== hw/rtl/ffas_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffas_dp
// Datapath: configuration, request registers, pool state, segment table
// and the segment arithmetic, driven by commands from the controller.
// ----------------------------------------------------------------------------
module ffas_dp #(
	parameter int MEMORY_TYPES = ffas_pkg::DEF_MEMORY_TYPES,
	parameter int HEAPS        = ffas_pkg::DEF_HEAPS,
	parameter int SEGMENTS     = ffas_pkg::DEF_SEGMENTS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ffas_pkg::cmd_t  cmd,
	output ffas_pkg::sts_t  sts,
	input  logic            op,
	input  logic [2:0]      memory_type,
	input  logic [35:0]     req_size,
	input  logic [5:0]      align_log2,
	input  logic [1:0]      free_heap,
	input  logic [35:0]     free_offset,
	input  logic            cfg_valid,
	input  logic [2:0]      cfg_index,
	input  logic [35:0]     cfg_data,
	output logic [2:0]      status,
	output logic [1:0]      heap_index,
	output logic [35:0]     block_offset,
	output logic [35:0]     block_size
);
	import ffas_pkg::*;

	localparam int POOLS  = MEMORY_TYPES * HEAPS;
	localparam int POOL_W = $clog2(POOLS);
	localparam int HEAP_W = $clog2(HEAPS);
	localparam int IDX_W  = $clog2(SEGMENTS);
	localparam int CNT_W  = $clog2(SEGMENTS + 1);
	localparam int DEPTH  = POOLS * SEGMENTS;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [W-1:0] heap_size_q [4];
	logic [W-1:0] thresh_q;
	logic         routing_q;
	logic [3:0]   types_q;
	logic [W-1:0] maxsz_q;
	logic [W-1:0] maxsz_c;

	logic         op_q;
	logic [2:0]   mt_q;
	logic [W-1:0] req_q;
	logic [5:0]   al_q;
	logic [1:0]   fh_q;
	logic [W-1:0] off_q;
	logic [W:0]   end_q;
	logic [W-1:0] mask_q;

	logic [CNT_W-1:0]  count_q [2**POOL_W];
	logic              opened_q [2**POOL_W];
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  pos_q;
	logic [HEAP_W-1:0] h_q;

	seg_t         cur_q;
	seg_t         prev_q;
	seg_t         next_q;
	seg_t         ins_q;
	logic         has_prev_q;
	logic         has_next_q;
	logic [W-1:0] pad_q;
	logic [W-1:0] aligned_q;
	logic [W-1:0] room_q;
	logic         pad_le_q;

	logic [2:0]   res_status_q;
	logic [1:0]   res_heap_q;
	logic [W-1:0] res_off_q;
	logic [W-1:0] res_size_q;

	logic [POOL_W-1:0] pool;
	logic [CNT_W-1:0]  cnt;
	logic [1:0]        hsel;
	logic              mt_bad;
	logic [W:0]        prev_end;
	logic [IDX_W-1:0]  rd_idx;
	logic [IDX_W-1:0]  wr_idx;
	logic              rd_en;
	logic              wr_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	seg_t              wr_data;
	seg_t              rdata;

	assign pool = POOL_W'(int'(mt_q) * HEAPS + int'(h_q));
	assign cnt  = count_q[pool];
	assign hsel = 2'(h_q);

	always_comb begin
		maxsz_c = '0;
		for (int h = 0; h < HEAPS; h++) begin
			if (heap_size_q[h] > maxsz_c) begin
				maxsz_c = heap_size_q[h];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_size_q[0] <= 36'd268435456;
			heap_size_q[1] <= 36'd268435456;
			heap_size_q[2] <= '0;
			heap_size_q[3] <= '0;
			thresh_q       <= '0;
			routing_q      <= 1'b0;
			types_q        <= 4'd8;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HEAP0:   heap_size_q[0] <= cfg_data;
				CFG_HEAP1:   heap_size_q[1] <= cfg_data;
				CFG_HEAP2:   heap_size_q[2] <= cfg_data;
				CFG_HEAP3:   heap_size_q[3] <= cfg_data;
				CFG_THRESH:  thresh_q       <= cfg_data;
				CFG_ROUTING: routing_q      <= cfg_data[0];
				CFG_TYPES:   types_q        <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		maxsz_q   <= maxsz_c;
		aligned_q <= cur_q.off + pad_q;
		room_q    <= cur_q.len - pad_q;
		pad_le_q  <= pad_q <= cur_q.len;
		if (cmd.load_req) begin
			op_q   <= op;
			mt_q   <= memory_type;
			req_q  <= req_size;
			al_q   <= align_log2;
			fh_q   <= free_heap;
			off_q  <= free_offset;
			end_q  <= {1'b0, free_offset} + {1'b0, req_size};
			mask_q <= (36'd1 << align_log2) - 36'd1;
		end
		if (cmd.cur_load) begin
			cur_q <= rdata;
			pad_q <= (~rdata.off + 36'd1) & mask_q;
		end
		if (cmd.scan_take) begin
			if (rdata.off <= off_q) begin
				prev_q <= rdata;
			end else begin
				next_q <= rdata;
			end
		end
		if (cmd.ins_load) begin
			if (op_q == OP_FREE) begin
				ins_q <= '{off: off_q, len: req_q};
			end else begin
				ins_q <= '{off: aligned_q + req_q, len: room_q - req_q};
			end
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_code;
			if (cmd.res_code != ST_OK) begin
				res_heap_q <= '0;
				res_off_q  <= '0;
				res_size_q <= '0;
			end else if (op_q == OP_FREE) begin
				res_heap_q <= fh_q;
				res_off_q  <= off_q;
				res_size_q <= req_q;
			end else begin
				res_heap_q <= 2'(h_q);
				res_off_q  <= aligned_q;
				res_size_q <= req_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < 2**POOL_W; p++) begin
				count_q[p]  <= '0;
				opened_q[p] <= 1'b0;
			end
			j_q        <= '0;
			pos_q      <= '0;
			h_q        <= '0;
			has_prev_q <= 1'b0;
			has_next_q <= 1'b0;
		end else begin
			if (cmd.load_req) begin
				has_prev_q <= 1'b0;
				has_next_q <= 1'b0;
			end
			if (cmd.scan_take) begin
				if (rdata.off <= off_q) begin
					has_prev_q <= 1'b1;
				end else begin
					has_next_q <= 1'b1;
				end
			end
			if (cmd.open_pool) begin
				opened_q[pool] <= 1'b1;
				count_q[pool]  <= (heap_size_q[hsel] != '0) ? CNT_W'(1) : '0;
			end else begin
				unique case (cmd.cnt_op)
					C_INC:   count_q[pool] <= cnt + CNT_W'(1);
					C_DEC:   count_q[pool] <= cnt - CNT_W'(1);
					default: begin
					end
				endcase
			end
			unique case (cmd.j_op)
				J_ZERO:  j_q <= '0;
				J_INC:   j_q <= j_q + CNT_W'(1);
				J_DEC:   j_q <= j_q - CNT_W'(1);
				J_CNT:   j_q <= cnt;
				default: begin
				end
			endcase
			unique case (cmd.pos_op)
				P_J:     pos_q <= j_q;
				P_J1:    pos_q <= j_q + CNT_W'(1);
				default: begin
				end
			endcase
			unique case (cmd.h_op)
				H_START: h_q <= (routing_q && req_q > thresh_q) ? HEAP_W'(1) : '0;
				H_FREE:  h_q <= fh_q[HEAP_W-1:0];
				H_INC:   h_q <= h_q + HEAP_W'(1);
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		rd_en  = cmd.rd_sel != RD_NONE;
		rd_idx = j_q[IDX_W-1:0];
		unique case (cmd.rd_sel)
			RD_JP1:  rd_idx = IDX_W'(j_q + CNT_W'(1));
			RD_JM1:  rd_idx = IDX_W'(j_q - CNT_W'(1));
			default: rd_idx = j_q[IDX_W-1:0];
		endcase
	end

	always_comb begin
		wr_en   = cmd.wr_sel != WR_NONE;
		wr_idx  = j_q[IDX_W-1:0];
		wr_data = rdata;
		unique case (cmd.wr_sel)
			WR_OPEN: begin
				wr_idx  = '0;
				wr_data = '{off: '0, len: heap_size_q[hsel]};
			end
			WR_INS:   wr_data = ins_q;
			WR_TAIL:  wr_data = '{off: cur_q.off + req_q, len: cur_q.len - req_q};
			WR_HEAD:  wr_data = '{off: cur_q.off, len: pad_q};
			WR_MBOTH: begin
				wr_idx  = IDX_W'(j_q - CNT_W'(1));
				wr_data = '{off: prev_q.off, len: prev_q.len + req_q + next_q.len};
			end
			WR_MPREV: begin
				wr_idx  = IDX_W'(j_q - CNT_W'(1));
				wr_data = '{off: prev_q.off, len: prev_q.len + req_q};
			end
			WR_MNEXT: wr_data = '{off: off_q, len: next_q.len + req_q};
			default:  wr_data = rdata;
		endcase
	end

	assign rd_addr = ADDR_W'(int'(pool) * SEGMENTS + int'(rd_idx));
	assign wr_addr = ADDR_W'(int'(pool) * SEGMENTS + int'(wr_idx));

	ffas_ram #(
		.WIDTH($bits(seg_t)),
		.DEPTH(DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rdata)
	);

	assign mt_bad   = ({1'b0, mt_q} >= types_q) || (int'(mt_q) >= MEMORY_TYPES);
	assign prev_end = {1'b0, prev_q.off} + {1'b0, prev_q.len};

	always_comb begin
		sts.is_free     = op_q == OP_FREE;
		sts.bad_alloc   = mt_bad || (int'(al_q) > ALIGN_MAX);
		sts.bad_free    = mt_bad || (int'(fh_q) >= HEAPS) || (end_q[W] && (end_q[W-1:0] != '0));
		sts.too_large   = req_q > maxsz_q;
		sts.zero_size   = req_q == '0;
		sts.opened      = opened_q[pool];
		sts.j_eq_cnt    = j_q == cnt;
		sts.j1_eq_cnt   = ({1'b0, j_q} + (CNT_W+1)'(1)) == {1'b0, cnt};
		sts.j_eq_pos    = j_q == pos_q;
		sts.heap_last   = int'(h_q) == HEAPS - 1;
		sts.fit         = pad_le_q && (req_q <= room_q);
		sts.pad_zero    = pad_q == '0;
		sts.room_eq_req = room_q == req_q;
		sts.table_full  = int'(cnt) >= SEGMENTS;
		sts.le          = rdata.off <= off_q;
		sts.f_bad       = (has_prev_q && prev_end > {1'b0, off_q})
			|| (has_next_q && {1'b0, next_q.off} < end_q);
		sts.mprev       = has_prev_q && prev_end == {1'b0, off_q};
		sts.mnext       = has_next_q && {1'b0, next_q.off} == end_q;
	end

	assign status       = res_status_q;
	assign heap_index   = res_heap_q;
	assign block_offset = res_off_q;
	assign block_size   = res_size_q;
endmodule

// ===== hw/rtl/ffas_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffas_ctrl
// Controller: sequences the table walk, the splits, merges and entry shifts,
// and the request and result handshakes.
// ----------------------------------------------------------------------------
module ffas_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  ffas_pkg::sts_t sts,
	output ffas_pkg::cmd_t cmd
);
	import ffas_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_FCHK, S_OPEN, S_ARD, S_ALD, S_ACALC, S_AEV,
		S_INS_CHK, S_INS_WR, S_RM_CHK, S_RM_WR, S_FRD, S_FLD, S_FDEC, S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = state_q == S_DONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.res_code = ST_OK;
		cmd.j_op     = J_HOLD;
		cmd.pos_op   = P_HOLD;
		cmd.h_op     = H_HOLD;
		cmd.rd_sel   = RD_NONE;
		cmd.wr_sel   = WR_NONE;
		cmd.cnt_op   = C_HOLD;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.is_free) begin
					cmd.h_op = H_FREE;
					if (sts.bad_free) begin
						cmd.res_load = 1'b1;
						cmd.res_code = ST_BAD;
						state_d      = S_DONE;
					end else begin
						state_d = S_FCHK;
					end
				end else begin
					priority if (sts.bad_alloc) begin
						cmd.res_load = 1'b1;
						cmd.res_code = ST_BAD;
						state_d      = S_DONE;
					end else if (sts.too_large) begin
						cmd.res_load = 1'b1;
						cmd.res_code = ST_TOO_LARGE;
						state_d      = S_DONE;
					end else begin
						cmd.h_op = H_START;
						state_d  = S_OPEN;
					end
				end
			end
			S_FCHK: begin
				priority if (!sts.opened) begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_BAD;
					state_d      = S_DONE;
				end else if (sts.zero_size) begin
					cmd.res_load = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.j_op = J_ZERO;
					state_d  = S_FRD;
				end
			end
			S_OPEN: begin
				if (!sts.opened) begin
					cmd.open_pool = 1'b1;
					cmd.wr_sel    = WR_OPEN;
				end
				cmd.j_op = J_ZERO;
				state_d  = S_ARD;
			end
			S_ARD: begin
				priority if (sts.j_eq_cnt && sts.heap_last) begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_NO_SPACE;
					state_d      = S_DONE;
				end else if (sts.j_eq_cnt) begin
					cmd.h_op = H_INC;
					state_d  = S_OPEN;
				end else begin
					cmd.rd_sel = RD_J;
					state_d    = S_ALD;
				end
			end
			S_ALD: begin
				cmd.cur_load = 1'b1;
				state_d      = S_ACALC;
			end
			S_ACALC: begin
				state_d = S_AEV;
			end
			S_AEV: begin
				priority if (!sts.fit) begin
					cmd.j_op = J_INC;
					state_d  = S_ARD;
				end else if (sts.pad_zero && sts.room_eq_req) begin
					cmd.res_load = 1'b1;
					cmd.pos_op   = P_J;
					state_d      = S_RM_CHK;
				end else if (sts.pad_zero) begin
					cmd.wr_sel   = WR_TAIL;
					cmd.res_load = 1'b1;
					state_d      = S_DONE;
				end else if (sts.room_eq_req) begin
					cmd.wr_sel   = WR_HEAD;
					cmd.res_load = 1'b1;
					state_d      = S_DONE;
				end else if (sts.table_full) begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_TABLE_FULL;
					state_d      = S_DONE;
				end else begin
					cmd.wr_sel   = WR_HEAD;
					cmd.res_load = 1'b1;
					cmd.ins_load = 1'b1;
					cmd.pos_op   = P_J1;
					cmd.j_op     = J_CNT;
					state_d      = S_INS_CHK;
				end
			end
			S_INS_CHK: begin
				if (sts.j_eq_pos) begin
					cmd.wr_sel = WR_INS;
					cmd.cnt_op = C_INC;
					state_d    = S_DONE;
				end else begin
					cmd.rd_sel = RD_JM1;
					state_d    = S_INS_WR;
				end
			end
			S_INS_WR: begin
				cmd.wr_sel = WR_SHIFT;
				cmd.j_op   = J_DEC;
				state_d    = S_INS_CHK;
			end
			S_RM_CHK: begin
				if (sts.j1_eq_cnt) begin
					cmd.cnt_op = C_DEC;
					state_d    = S_DONE;
				end else begin
					cmd.rd_sel = RD_JP1;
					state_d    = S_RM_WR;
				end
			end
			S_RM_WR: begin
				cmd.wr_sel = WR_SHIFT;
				cmd.j_op   = J_INC;
				state_d    = S_RM_CHK;
			end
			S_FRD: begin
				if (sts.j_eq_cnt) begin
					state_d = S_FDEC;
				end else begin
					cmd.rd_sel = RD_J;
					state_d    = S_FLD;
				end
			end
			S_FLD: begin
				cmd.scan_take = 1'b1;
				if (sts.le) begin
					cmd.j_op = J_INC;
					state_d  = S_FRD;
				end else begin
					state_d = S_FDEC;
				end
			end
			S_FDEC: begin
				priority if (sts.f_bad) begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_BAD;
					state_d      = S_DONE;
				end else if (sts.mprev && sts.mnext) begin
					cmd.wr_sel   = WR_MBOTH;
					cmd.res_load = 1'b1;
					cmd.pos_op   = P_J;
					state_d      = S_RM_CHK;
				end else if (sts.mprev) begin
					cmd.wr_sel   = WR_MPREV;
					cmd.res_load = 1'b1;
					state_d      = S_DONE;
				end else if (sts.mnext) begin
					cmd.wr_sel   = WR_MNEXT;
					cmd.res_load = 1'b1;
					state_d      = S_DONE;
				end else if (sts.table_full) begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_TABLE_FULL;
					state_d      = S_DONE;
				end else begin
					cmd.ins_load = 1'b1;
					cmd.res_load = 1'b1;
					cmd.pos_op   = P_J;
					cmd.j_op     = J_CNT;
					state_d      = S_INS_CHK;
				end
			end
			S_DONE: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ===== hw/rtl/ffas_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffas_chk
// Port-level checks of the suballocator core, bound to the top level.
// ----------------------------------------------------------------------------
module ffas_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [1:0]  heap_index,
	input logic [35:0] block_offset,
	input logic [35:0] block_size
);
	import ffas_pkg::*;

	// A new request cannot produce its result in the very next cycle.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !out_valid)
		else $error("result appeared right after a request transaction");

	// The block takes no request while a result waits.
	a_busy_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request port open while a result is pending");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status)
			&& $stable(block_offset) && $stable(block_size)))
		else $error("stalled result changed");

	// A failed request reports all-zero fields.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |->
			(heap_index == 2'd0 && block_offset == '0 && block_size == '0))
		else $error("failed request has nonzero fields");
endmodule

bind first_fit_aligned_suballocator_core ffas_chk u_chk (.*);

// ===== test/first_fit_aligned_suballocator_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_aligned_suballocator_core_checker
// Watches the request, result and configuration channels of the suballocator,
// keeps its own copy of every pool's free segment table, predicts the result
// of each request and compares it field by field with the result returned.
// ----------------------------------------------------------------------------
module first_fit_aligned_suballocator_core_checker #(
	parameter int MEMORY_TYPES = ffas_pkg::DEF_MEMORY_TYPES,
	parameter int HEAPS        = ffas_pkg::DEF_HEAPS,
	parameter int SEGMENTS     = ffas_pkg::DEF_SEGMENTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        op,
	input  logic [2:0]  memory_type,
	input  logic [35:0] req_size,
	input  logic [5:0]  align_log2,
	input  logic [1:0]  free_heap,
	input  logic [35:0] free_offset,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [1:0]  heap_index,
	input  logic [35:0] block_offset,
	input  logic [35:0] block_size,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [35:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	import ffas_pkg::*;

	localparam int POOLS = MEMORY_TYPES * HEAPS;

	typedef struct packed {
		status_t      st;
		logic [1:0]   heap;
		logic [W-1:0] off;
		logic [W-1:0] size;
	} grant_t;

	logic [W-1:0] seg_off [POOLS][SEGMENTS];
	logic [W-1:0] seg_len [POOLS][SEGMENTS];
	int           seg_cnt [POOLS];
	bit           opened  [POOLS];
	logic [W-1:0] heap_bytes [4];
	logic [W-1:0] thresh;
	logic         routing;
	logic [3:0]   types;
	grant_t       grants_due [$];

	assign pending = grants_due.size();

	task automatic seg_put(int p, int pos, logic [W-1:0] o, logic [W-1:0] l);
		for (int i = seg_cnt[p]; i > pos; i--) begin
			seg_off[p][i] = seg_off[p][i-1];
			seg_len[p][i] = seg_len[p][i-1];
		end
		seg_off[p][pos] = o;
		seg_len[p][pos] = l;
		seg_cnt[p]++;
	endtask

	task automatic seg_drop(int p, int pos);
		for (int i = pos; i + 1 < seg_cnt[p]; i++) begin
			seg_off[p][i] = seg_off[p][i+1];
			seg_len[p][i] = seg_len[p][i+1];
		end
		seg_cnt[p]--;
	endtask

	task automatic carve(int mt, logic [W-1:0] req, int al, output grant_t g);
		logic [63:0] a, o, l, aligned, pad, room, biggest;
		int h, p;
		a = 64'd1 << al;
		biggest = 0;
		g = '{st: ST_NO_SPACE, heap: 0, off: 0, size: 0};
		for (int k = 0; k < HEAPS; k++)
			if (heap_bytes[k] > biggest)
				biggest = heap_bytes[k];
		if (req > biggest) begin
			g.st = ST_TOO_LARGE;
			return;
		end
		h = (routing && req > thresh) ? 1 : 0;
		for (; h < HEAPS; h++) begin
			p = mt * HEAPS + h;
			if (!opened[p]) begin
				opened[p] = 1;
				seg_cnt[p] = 0;
				if (heap_bytes[h] > 0)
					seg_put(p, 0, 0, heap_bytes[h]);
			end
			for (int i = 0; i < seg_cnt[p]; i++) begin
				o = seg_off[p][i];
				l = seg_len[p][i];
				aligned = (o + a - 1) & ~(a - 1);
				pad = aligned - o;
				if (pad > l)
					continue;
				room = l - pad;
				if (req > room)
					continue;
				if (pad == 0) begin
					if (req == room)
						seg_drop(p, i);
					else begin
						seg_off[p][i] = o + req;
						seg_len[p][i] = l - req;
					end
				end else if (room != req) begin
					if (seg_cnt[p] >= SEGMENTS) begin
						g.st = ST_TABLE_FULL;
						return;
					end
					seg_len[p][i] = pad;
					seg_put(p, i + 1, aligned + req, room - req);
				end else
					seg_len[p][i] = pad;
				g = '{st: ST_OK, heap: h[1:0], off: aligned[W-1:0], size: req};
				return;
			end
		end
	endtask

	task automatic give_back(int mt, int h, logic [W-1:0] off, logic [W-1:0] sz,
			output grant_t g);
		logic [63:0] fin;
		int p, pos;
		bit mp, mn;
		g = '{st: ST_BAD, heap: 0, off: 0, size: 0};
		fin = 64'(off) + 64'(sz);
		if (h >= HEAPS)
			return;
		p = mt * HEAPS + h;
		if (!opened[p] || fin > 64'h10_0000_0000)
			return;
		if (sz == 0) begin
			g = '{st: ST_OK, heap: h[1:0], off: off, size: 0};
			return;
		end
		pos = 0;
		while (pos < seg_cnt[p] && seg_off[p][pos] <= off)
			pos++;
		if (pos > 0 && 64'(seg_off[p][pos-1]) + seg_len[p][pos-1] > off)
			return;
		if (pos < seg_cnt[p] && seg_off[p][pos] < fin)
			return;
		mp = pos > 0 && 64'(seg_off[p][pos-1]) + seg_len[p][pos-1] == off;
		mn = pos < seg_cnt[p] && seg_off[p][pos] == fin;
		if (mp && mn) begin
			seg_len[p][pos-1] += sz + seg_len[p][pos];
			seg_drop(p, pos);
		end else if (mp)
			seg_len[p][pos-1] += sz;
		else if (mn) begin
			seg_off[p][pos] = off;
			seg_len[p][pos] += sz;
		end else begin
			if (seg_cnt[p] >= SEGMENTS) begin
				g.st = ST_TABLE_FULL;
				return;
			end
			seg_put(p, pos, off, sz);
		end
		g = '{st: ST_OK, heap: h[1:0], off: off, size: sz};
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_t g, want;
		if (!arst_n) begin
			for (int p = 0; p < POOLS; p++) begin
				seg_cnt[p] = 0;
				opened[p] = 0;
			end
			heap_bytes = '{36'd268435456, 36'd268435456, 36'd0, 36'd0};
			thresh = 0;
			routing = 0;
			types = 4'd8;
			grants_due.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (grants_due.size() == 0) begin
					$display("%0t: unexpected result status=%0d", $time, status);
					fail_count++;
				end else begin
					want = grants_due.pop_front();
					if (status !== want.st || heap_index !== want.heap ||
							block_offset !== want.off || block_size !== want.size) begin
						$display("%0t: mismatch expected st=%0d heap=%0d off=%h size=%h",
							$time, want.st, want.heap, want.off, want.size);
						$display("%0t:            actual st=%0d heap=%0d off=%h size=%h",
							$time, status, heap_index, block_offset, block_size);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (memory_type >= types || memory_type >= MEMORY_TYPES)
					g = '{st: ST_BAD, heap: 0, off: 0, size: 0};
				else if (op == OP_ALLOC) begin
					if (align_log2 > ALIGN_MAX)
						g = '{st: ST_BAD, heap: 0, off: 0, size: 0};
					else
						carve(memory_type, req_size, align_log2, g);
				end else
					give_back(memory_type, free_heap, free_offset, req_size, g);
				grants_due = {grants_due, g};
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_HEAP0, CFG_HEAP1, CFG_HEAP2, CFG_HEAP3: heap_bytes[cfg_index] = cfg_data;
					CFG_THRESH: thresh = cfg_data;
					CFG_ROUTING: routing = cfg_data[0];
					CFG_TYPES: types = cfg_data[3:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== test/first_fit_aligned_suballocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_aligned_suballocator_core_tb
// Drives directed and random allocate and free transactions through several
// heap settings, with random gaps and result stalls, and reports the verdict
// of the checker.
// ----------------------------------------------------------------------------
module first_fit_aligned_suballocator_core_tb;
	import ffas_pkg::*;

	localparam int WATCH_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid, in_stall, op;
	logic [2:0]  memory_type;
	logic [35:0] req_size, free_offset;
	logic [5:0]  align_log2;
	logic [1:0]  free_heap;
	logic        out_valid, out_stall;
	logic [2:0]  status;
	logic [1:0]  heap_index;
	logic [35:0] block_offset, block_size;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [35:0] cfg_data;
	int          fail_count, pending;
	int          idle_pct;
	int          quiet;
	logic [1:0]  held_heap [$];
	logic [2:0]  held_type [$];
	logic [35:0] held_off [$], held_size [$];

	first_fit_aligned_suballocator_core u_dut (.*);

	first_fit_aligned_suballocator_core_checker u_chk (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > WATCH_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < idle_pct);

	task automatic write_reg(logic [2:0] idx, logic [35:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send(logic o, logic [2:0] mt, logic [35:0] sz, logic [5:0] al,
			logic [1:0] fh, logic [35:0] fo);
		while ($urandom_range(99) < idle_pct)
			@(negedge clk);
		in_valid <= 1'b1;
		op <= o;
		memory_type <= mt;
		req_size <= sz;
		align_log2 <= al;
		free_heap <= fh;
		free_offset <= fo;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (200)
			@(negedge clk);
	endtask

	task automatic random_phase(int n, logic [35:0] span);
		logic [35:0] sz;
		int k;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 45 && held_off.size() > 0) begin
				k = $urandom_range(held_off.size() - 1);
				send(OP_FREE, held_type[k], held_size[k], 0, held_heap[k], held_off[k]);
				held_off.delete(k);
				held_size.delete(k);
				held_heap.delete(k);
				held_type.delete(k);
			end else if ($urandom_range(99) < 85) begin
				sz = {$urandom, $urandom} % (span + 1);
				if ($urandom_range(3) == 0)
					sz = $urandom_range(64);
				send(OP_ALLOC, $urandom_range(7), sz, $urandom_range(12), $urandom,
					$urandom);
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
				if (status == ST_OK && op == OP_ALLOC && block_size != 0) begin
					held_off = {held_off, block_offset};
					held_size = {held_size, block_size};
					held_heap = {held_heap, heap_index};
					held_type = {held_type, memory_type};
				end
			end else begin
				send($urandom, $urandom, {$urandom, $urandom}, $urandom, $urandom,
					{$urandom, $urandom});
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_ALLOC;
		memory_type = 0;
		req_size = 0;
		align_log2 = 0;
		free_heap = 0;
		free_offset = 0;
		cfg_valid = 1'b0;
		cfg_index = CFG_HEAP0;
		cfg_data = 0;
		idle_pct = 34;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(OP_ALLOC, 0, 36'd0, 0, 0, 0);
		send(OP_ALLOC, 0, 36'd100, 6'd4, 0, 0);
		send(OP_ALLOC, 0, 36'd100, 6'd35, 0, 0);
		send(OP_ALLOC, 0, 36'd1, 6'd36, 0, 0);
		send(OP_ALLOC, 0, 36'd1, 6'd63, 0, 0);
		send(OP_ALLOC, 7, 36'hF_FFFF_FFFF, 0, 0, 0);
		send(OP_ALLOC, 1, 36'd268435456, 0, 0, 0);
		send(OP_ALLOC, 1, 36'd268435456, 0, 0, 0);
		send(OP_ALLOC, 1, 36'd1, 0, 0, 0);
		send(OP_FREE, 1, 36'd268435456, 0, 0, 0);
		send(OP_FREE, 1, 36'd10, 0, 0, 36'd5);
		send(OP_FREE, 0, 36'd0, 0, 2'd3, 0);
		send(OP_FREE, 5, 36'd16, 0, 0, 0);
		send(OP_FREE, 0, 36'd16, 0, 0, 36'hF_FFFF_FFF8);
		send(OP_FREE, 0, 36'd0, 0, 0, 36'd77);
		send(OP_FREE, 0, 36'd100, 0, 0, 36'd16);
		send(OP_FREE, 0, 36'd16, 0, 0, 36'd0);
		drain();

		write_reg(CFG_TYPES, 4'd1);
		write_reg(CFG_HEAP0, 36'd0);
		write_reg(CFG_HEAP1, 36'hF_FFFF_FFFF);
		write_reg(CFG_HEAP2, 36'hF_FFFF_FFFF);
		write_reg(CFG_HEAP3, 36'd5);
		write_reg(CFG_THRESH, 36'hF_FFFF_FFFF);
		write_reg(CFG_ROUTING, 1'b1);
		send(OP_ALLOC, 3, 36'd4, 0, 0, 0);
		send(OP_ALLOC, 0, 36'hF_FFFF_FFFF, 0, 0, 0);
		drain();

		write_reg(CFG_TYPES, 4'd8);
		write_reg(CFG_HEAP0, 36'd4096);
		write_reg(CFG_HEAP1, 36'd4096);
		write_reg(CFG_THRESH, 36'd64);
		idle_pct = 0;
		random_phase(150, 36'd300);
		drain();
		idle_pct = 34;
		random_phase(350, 36'd300);
		drain();

		write_reg(CFG_ROUTING, 1'b0);
		write_reg(CFG_THRESH, 36'd0);
		write_reg(CFG_TYPES, 4'd15);
		random_phase(480, 36'h8_0000_0000);
		drain();

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/ffas_pkg.sv
hw/rtl/ffas_ram.sv
hw/rtl/ffas_dp.sv
hw/rtl/ffas_ctrl.sv
hw/rtl/first_fit_aligned_suballocator_core.sv
hw/rtl/ffas_chk.sv
test/first_fit_aligned_suballocator_core_checker.sv
test/first_fit_aligned_suballocator_core_tb.sv
